// ===== hdl/mdlr_pkg.sv =====
// ============================================================================
// mdlr_pkg: shared types and constants of the marked delay line ring
// Field widths, request kind codes and the per-cell control bundle.
// ============================================================================
`default_nettype none

package mdlr_pkg;

    localparam int KIND_W    = 3;
    localparam int DATA_W    = 64;
    localparam int MARK_W    = 32;
    localparam int OFF_W     = 6;
    localparam int LEN_W     = 7;
    localparam int LEN_RESET = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH    = 3'd0,
        KIND_POP     = 3'd1,
        KIND_TOP     = 3'd2,
        KIND_ACCESS  = 3'd3,
        KIND_SETMARK = 3'd4,
        KIND_FLUSH   = 3'd5
    } t_kind;

    // control for one storage cell
    typedef struct packed {
        logic shift;    // take neighbor's entry
        logic wr_vec;   // load new vector
        logic wr_mark;  // load new mark
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/mdlr_req_if.sv =====
// ============================================================================
// mdlr_req_if: request channel
// Valid/ready channel carrying one operation of the delay line.
// ============================================================================
`default_nettype none

interface mdlr_req_if import mdlr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [DATA_W-1:0]        data_in;
    logic signed [MARK_W-1:0] mark_in;
    logic [OFF_W-1:0]         offset;

    modport source (output valid, kind, data_in, mark_in, offset, input ready);
    modport sink   (input valid, kind, data_in, mark_in, offset, output ready);
endinterface

`default_nettype wire

// ===== hdl/mdlr_rsp_if.sv =====
// ============================================================================
// mdlr_rsp_if: response channel
// Valid/ready channel carrying one result of the delay line.
// ============================================================================
`default_nettype none

interface mdlr_rsp_if import mdlr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [DATA_W-1:0]        data_out;
    logic signed [MARK_W-1:0] mark_out;
    logic [LEN_W-1:0]         stored_count;
    logic [LEN_W-1:0]         vacant_count;
    logic                     error;

    modport source (output valid, data_out, mark_out, stored_count, vacant_count, error,
                    input ready);
    modport sink   (input valid, data_out, mark_out, stored_count, vacant_count, error,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/marked_delay_line_ring_core.sv =====
// ============================================================================
// marked_delay_line_ring_core: marked delay line on a recirculating ring
// Ring of storage cells that rotates until the addressed slot sits in the
// head cell, where every read and write of a vector or mark takes place.
// ============================================================================
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-----------------------------------------
//  i_req     | in  | valid/ready   | kind, data_in, mark_in, offset
//  o_rsp     | out | valid/ready   | data_out, mark_out, stored/vacant, error
//  cfg       | in  | i_cfg_we      | i_cfg_data = active length
//
//  One transaction at a time. Push, pop, top, access and set-mark are
//  accepted, then rotate the ring k times, where k (0 .. L-1) is the number
//  of ring rotations needed to bring the addressed slot to the head cell,
//  then pass the result to the output register before the next acceptance.
//  Refused operations, flush and unused kinds go straight to the result.
//  Reset is synchronous, active low; the cells themselves are not cleared.
//  A result waiting in the output register does not block acceptance of the
//  next request; that request holds in its last cycle until the register frees.
//
`default_nettype none

module marked_delay_line_ring_core import mdlr_pkg::*; #(
    parameter int DEPTH     = 64,
    parameter int VEC_WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    mdlr_req_if.sink              i_req,
    mdlr_rsp_if.source            o_rsp
);

    localparam int AW = $clog2(DEPTH);          // slot index
    localparam int CW = $clog2(DEPTH + 1);      // counts up to DEPTH
    localparam int PW = ((AW > OFF_W) ? AW : OFF_W) + 1;
    localparam logic [CW-1:0] RST_LEN = (DEPTH < LEN_RESET) ? CW'(DEPTH) : CW'(LEN_RESET);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEEK = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_MARK  = 2'd3
    } t_act;

    // clamp the length register to 1..DEPTH
    function automatic logic [CW-1:0] f_clamp(input logic [LEN_W-1:0] v);
        logic [CW-1:0] l;
        if (v == '0) begin
            l = CW'(1);
        end else if (32'(v) > DEPTH) begin
            l = CW'(DEPTH);
        end else begin
            l = CW'(v);
        end
        return l;
    endfunction

    // control state
    t_state        r_state,  n_state;
    logic [CW-1:0] r_len,    n_len;
    logic [AW-1:0] r_newest, n_newest;
    logic [AW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_vacant, n_vacant;
    logic [AW-1:0] r_rot,    n_rot;      // logical slot held in the head cell
    logic          r_ovalid, n_ovalid;

    // per-transaction payload
    t_act                 r_act,      n_act;
    logic [AW-1:0]        r_target,   n_target;
    logic [VEC_WIDTH-1:0] r_wvec,     n_wvec;
    logic [MARK_W-1:0]    r_wmark,    n_wmark;
    logic [VEC_WIDTH-1:0] r_res_vec,  n_res_vec;
    logic [MARK_W-1:0]    r_res_mark, n_res_mark;
    logic                 r_res_err,  n_res_err;

    // output register
    logic [VEC_WIDTH-1:0] r_o_vec,    n_o_vec;
    logic [MARK_W-1:0]    r_o_mark,   n_o_mark;
    logic [CW-1:0]        r_o_stored, n_o_stored;
    logic [CW-1:0]        r_o_vacant, n_o_vacant;
    logic                 r_o_err,    n_o_err;

    // cell chain
    logic [VEC_WIDTH-1:0] w_vec      [DEPTH];
    logic [MARK_W-1:0]    w_mark     [DEPTH];
    logic [VEC_WIDTH-1:0] w_nbr_vec  [DEPTH];
    logic [MARK_W-1:0]    w_nbr_mark [DEPTH];
    t_cell_ctl            w_ctl      [DEPTH];
    logic                 w_shift;
    logic                 w_wr_vec;
    logic                 w_wr_mark;

    // pointer arithmetic
    logic          w_accept;
    logic [CW-1:0] w_stored;
    logic [AW-1:0] w_last;
    logic [AW-1:0] w_newest_nx;
    logic [AW-1:0] w_oldest_nx;
    logic [AW-1:0] w_rot_nx;
    logic [PW-1:0] w_diff;
    logic [PW-1:0] w_diff_wrap;
    logic [AW-1:0] w_pos;
    logic          w_hit;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_stored    = r_len - r_vacant;
    assign w_last      = AW'(r_len - CW'(1));
    assign w_newest_nx = (r_newest == w_last) ? '0 : r_newest + AW'(1);
    assign w_oldest_nx = (r_oldest == w_last) ? '0 : r_oldest + AW'(1);
    assign w_rot_nx    = (r_rot == w_last)    ? '0 : r_rot + AW'(1);

    // slot 'offset' entries back from the newest, wrapped into the ring
    assign w_diff      = PW'(r_newest) - PW'(i_req.offset);
    assign w_diff_wrap = w_diff + PW'(r_len);
    assign w_pos       = w_diff[PW-1] ? w_diff_wrap[AW-1:0] : w_diff[AW-1:0];

    assign w_hit     = (r_state == ST_SEEK) && (r_rot == r_target);
    assign w_shift   = (r_state == ST_SEEK) && (r_rot != r_target);
    assign w_wr_vec  = w_hit && (r_act == ACT_WRITE);
    assign w_wr_mark = w_hit && ((r_act == ACT_WRITE) || (r_act == ACT_MARK));

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_newest   = r_newest;
        n_oldest   = r_oldest;
        n_vacant   = r_vacant;
        n_rot      = r_rot;
        n_ovalid   = r_ovalid;
        n_act      = r_act;
        n_target   = r_target;
        n_wvec     = r_wvec;
        n_wmark    = r_wmark;
        n_res_vec  = r_res_vec;
        n_res_mark = r_res_mark;
        n_res_err  = r_res_err;
        n_o_vec    = r_o_vec;
        n_o_mark   = r_o_mark;
        n_o_stored = r_o_stored;
        n_o_vacant = r_o_vacant;
        n_o_err    = r_o_err;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        if (i_cfg_we) begin
            // length write empties the ring
            n_len    = f_clamp(i_cfg_data);
            n_newest = AW'(n_len - CW'(1));
            n_oldest = '0;
            n_vacant = n_len;
            n_rot    = '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        n_state    = ST_DONE;
                        n_act      = ACT_NONE;
                        n_res_err  = 1'b0;
                        n_res_vec  = '0;
                        n_res_mark = '0;
                        n_wvec     = VEC_WIDTH'(i_req.data_in);
                        n_wmark    = $unsigned(i_req.mark_in);
                        case (i_req.kind)
                            KIND_PUSH: begin
                                n_target = w_newest_nx;
                                n_newest = w_newest_nx;
                                if (r_vacant != '0) begin
                                    n_vacant = r_vacant - CW'(1);
                                end else begin
                                    n_oldest = w_oldest_nx;   // overwrite oldest
                                end
                                n_act   = ACT_WRITE;
                                n_state = ST_SEEK;
                            end
                            KIND_POP, KIND_TOP: begin
                                if (w_stored == '0) begin
                                    n_res_err = 1'b1;
                                end else begin
                                    n_target = r_oldest;
                                    n_act    = ACT_READ;
                                    n_state  = ST_SEEK;
                                    if (i_req.kind == KIND_POP) begin
                                        n_oldest = w_oldest_nx;
                                        n_vacant = r_vacant + CW'(1);
                                    end
                                end
                            end
                            KIND_ACCESS, KIND_SETMARK: begin
                                if (PW'(i_req.offset) >= PW'(w_stored)) begin
                                    n_res_err = 1'b1;
                                end else begin
                                    n_target = w_pos;
                                    n_act    = (i_req.kind == KIND_ACCESS) ? ACT_READ
                                                                           : ACT_MARK;
                                    n_state  = ST_SEEK;
                                end
                            end
                            KIND_FLUSH: begin
                                n_newest = w_last;
                                n_oldest = '0;
                                n_vacant = r_len;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SEEK: begin
                    if (w_hit) begin
                        if (r_act == ACT_READ) begin
                            n_res_vec  = w_vec[0];
                            n_res_mark = w_mark[0];
                        end
                        n_state = ST_DONE;
                    end else begin
                        n_rot = w_rot_nx;
                    end
                end
                ST_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        n_ovalid   = 1'b1;
                        n_o_vec    = r_res_vec;
                        n_o_mark   = r_res_mark;
                        n_o_err    = r_res_err;
                        n_o_stored = r_len - r_vacant;
                        n_o_vacant = r_vacant;
                        n_state    = ST_IDLE;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len    <= RST_LEN;
            r_newest <= AW'(RST_LEN - CW'(1));
            r_oldest <= '0;
            r_vacant <= RST_LEN;
            r_rot    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_newest <= n_newest;
            r_oldest <= n_oldest;
            r_vacant <= n_vacant;
            r_rot    <= n_rot;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_target   <= n_target;
        r_wvec     <= n_wvec;
        r_wmark    <= n_wmark;
        r_res_vec  <= n_res_vec;
        r_res_mark <= n_res_mark;
        r_res_err  <= n_res_err;
        r_o_vec    <= n_o_vec;
        r_o_mark   <= n_o_mark;
        r_o_stored <= n_o_stored;
        r_o_vacant <= n_o_vacant;
        r_o_err    <= n_o_err;
    end

    // Ring of cells: each cell takes from the next one up, the cell at the
    // active length's end closes the loop from the head cell. Cells past the
    // active length form a chain fed from the head cell and are never read.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign w_nbr_vec[i]  = (r_len == CW'(i + 1)) ? w_vec[0]  : w_vec[(i + 1) % DEPTH];
        assign w_nbr_mark[i] = (r_len == CW'(i + 1)) ? w_mark[0] : w_mark[(i + 1) % DEPTH];

        if (i == 0) begin : g_head
            assign w_ctl[i] = '{shift: w_shift, wr_vec: w_wr_vec, wr_mark: w_wr_mark};
        end else begin : g_body
            assign w_ctl[i] = '{shift: w_shift, wr_vec: 1'b0, wr_mark: 1'b0};
        end

        mdlr_cell #(
            .VEC_WIDTH (VEC_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[i]),
            .i_nbr_vec  (w_nbr_vec[i]),
            .i_nbr_mark (w_nbr_mark[i]),
            .i_new_vec  (r_wvec),
            .i_new_mark (r_wmark),
            .o_vec      (w_vec[i]),
            .o_mark     (w_mark[i])
        );
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.data_out     = DATA_W'(r_o_vec);
    assign o_rsp.mark_out     = $signed(r_o_mark);
    assign o_rsp.stored_count = LEN_W'(r_o_stored);
    assign o_rsp.vacant_count = LEN_W'(r_o_vacant);
    assign o_rsp.error        = r_o_err;

endmodule

`default_nettype wire

// ===== hdl/mdlr_cell.sv =====
// ============================================================================
// mdlr_cell: one ring slot
// Holds a vector and its mark; shifts from its neighbor or loads new data.
// ============================================================================
`default_nettype none

module mdlr_cell import mdlr_pkg::*; #(
    parameter int VEC_WIDTH = 64
) (
    input  wire logic                 i_clk,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [VEC_WIDTH-1:0] i_nbr_vec,
    input  wire logic [MARK_W-1:0]    i_nbr_mark,
    input  wire logic [VEC_WIDTH-1:0] i_new_vec,
    input  wire logic [MARK_W-1:0]    i_new_mark,
    output logic      [VEC_WIDTH-1:0] o_vec,
    output logic      [MARK_W-1:0]    o_mark
);

    logic [VEC_WIDTH-1:0] r_vec;
    logic [MARK_W-1:0]    r_mark;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_vec  <= i_nbr_vec;
            r_mark <= i_nbr_mark;
        end else begin
            if (i_ctl.wr_vec) begin
                r_vec <= i_new_vec;
            end
            if (i_ctl.wr_mark) begin
                r_mark <= i_new_mark;
            end
        end
    end

    assign o_vec  = r_vec;
    assign o_mark = r_mark;

endmodule

`default_nettype wire

// ===== hdl/mdlr_checker.sv =====
// ============================================================================
// mdlr_checker: port-level assertions for the marked delay line ring
// Tracks the active length from the config port and checks the results.
// ============================================================================
`default_nettype none

module mdlr_checker import mdlr_pkg::*; #(
    parameter int DEPTH = 64
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_cfg_we,
    input wire logic [LEN_W-1:0] i_cfg_data,
    mdlr_req_if.sink             i_req,
    mdlr_rsp_if.source           o_rsp
);

    function automatic logic [LEN_W:0] f_clamp(input logic [LEN_W-1:0] v);
        logic [LEN_W:0] l;
        if (v == '0) begin
            l = (LEN_W + 1)'(1);
        end else if (32'(v) > DEPTH) begin
            l = (LEN_W + 1)'(DEPTH);
        end else begin
            l = {1'b0, v};
        end
        return l;
    endfunction

    logic [LEN_W:0] r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= f_clamp(LEN_W'(LEN_RESET));
        end else if (i_cfg_we) begin
            r_len <= f_clamp(i_cfg_data);
        end
    end

    // stored plus vacant always adds up to the active length
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ({1'b0, o_rsp.stored_count} + {1'b0, o_rsp.vacant_count}) == r_len)
        else $error("stored + vacant differs from active length");

    // refused operations return no payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.error |-> o_rsp.data_out == '0 && o_rsp.mark_out == '0)
        else $error("error result carries data");

    // one transaction in flight: no acceptance on the cycle after one
    a_one_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted back to back");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result valid right after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.data_out)
            && $stable(o_rsp.mark_out) && $stable(o_rsp.stored_count)
            && $stable(o_rsp.error))
        else $error("stalled result changed");

endmodule

bind marked_delay_line_ring_core mdlr_checker #(
    .DEPTH (DEPTH)
) u_mdlr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_cfg_we   (i_cfg_we),
    .i_cfg_data (i_cfg_data),
    .i_req      (i_req),
    .o_rsp      (o_rsp)
);

`default_nettype wire
